// ----- rtl/link_post_sequencer_macros.svh -----
// Assertion macros for the checker file.
`ifndef LINK_POST_SEQUENCER_MACROS_SVH
`define LINK_POST_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define LPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define LPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lps_pkg;

  // Result action codes
  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_POWER_ON  = 2'd1,
    ACT_POWER_OFF = 2'd2,
    ACT_SEND      = 2'd3
  } action_e;

  // Input item kinds
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_PACKET = 2'd1;
  localparam logic [1:0] FUNC_POST   = 2'd2;

  // Sequencer phases
  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_POWER_WAIT = 4'd1;
  localparam logic [3:0] PH_WIFI_ACK   = 4'd2;
  localparam logic [3:0] PH_WIFI_CONN  = 4'd3;
  localparam logic [3:0] PH_MQTT_ACK   = 4'd4;
  localparam logic [3:0] PH_MQTT_CONN  = 4'd5;
  localparam logic [3:0] PH_POST_ACK   = 4'd6;
  localparam logic [3:0] PH_POST_WAIT  = 4'd7;
  localparam logic [3:0] PH_SHUTDOWN   = 4'd8;

  // Event flag bit positions
  localparam int unsigned FL_POST      = 0;
  localparam int unsigned FL_WIFI_ACK  = 1;
  localparam int unsigned FL_WIFI_CONN = 2;
  localparam int unsigned FL_MQTT_ACK  = 3;
  localparam int unsigned FL_MQTT_CONN = 4;
  localparam int unsigned FL_POST_ACK  = 5;
  localparam int unsigned FL_WPOSTED   = 6;
  localparam int unsigned FL_POSTED    = 7;
  localparam int unsigned FL_COMPLETE  = 8;

  // Status packet argument bits
  localparam int unsigned ST_WIFI_CONN = 0;
  localparam int unsigned ST_MQTT_CONN = 1;
  localparam int unsigned ST_WPOSTED   = 2;

  // Poll timer reloads
  localparam logic [6:0] POLL_OK_RELOAD    = 7'd100;
  localparam logic [6:0] POLL_RETRY_RELOAD = 7'd10;

  // Register map (word index = paddr[4:2])
  localparam int unsigned APB_AW = 5;
  localparam logic [2:0] REG_ACK_CODE     = 3'd0;
  localparam logic [2:0] REG_STATUS_CODE  = 3'd1;
  localparam logic [2:0] REG_WIFI_CODE    = 3'd2;
  localparam logic [2:0] REG_MQTT_CODE    = 3'd3;
  localparam logic [2:0] REG_WEATHER_CODE = 3'd4;
  localparam logic [2:0] REG_POWER_WAIT   = 3'd5;
  localparam logic [2:0] REG_ACK_WAIT     = 3'd6;
  localparam logic [2:0] REG_CONN_WAIT    = 3'd7;

  // Stream widths
  localparam int unsigned IN_DATA_W  = 120;
  localparam int unsigned OUT_DATA_W = 112;

  // One queued item: its first result, plus an optional status poll beat
  typedef struct packed {
    action_e            action;
    logic [7:0]         code;
    logic signed [31:0] temperature;
    logic [31:0]        pressure;
    logic [31:0]        humidity;
    logic               post_acc;
    logic               two;
    logic [7:0]         poll_code;
    logic               posted;
    logic               complete;
  } lps_entry_t;

endpackage

`default_nettype wire

// ----- rtl/link_post_sequencer.sv -----
// An item's result is registered in the item queue before it is on the master side.
// Throughput: one item per cycle while items give one result and the master side is ready;
// a tick that gives a machine action and a status poll gives a machine action beat and a
// status poll beat. A two-entry item queue sets the figure: the slave side is ready while the queue has a free entry.
// Reset (rst_ni low, asynchronous): phase idle, timers and flags zero, registers to defaults.
`timescale 1ns / 1ps
`default_nettype none

module link_post_sequencer
  import lps_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // input stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // usb_reserved, send_ok, poll_send_ok, packet_type[7:0], packet_arg[7:0],
  // pressure_in[31:0], temperature_in[31:0], humidity_in[31:0], zero fill
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // func[1:0]
  input  wire logic [1:0]            s_axis_tuser,
  // result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // command_code[7:0], payload_temperature[31:0], payload_pressure[31:0],
  // payload_humidity[31:0], post_accepted, posted_flag, complete_flag, zero fill
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // action[1:0]
  output logic [1:0]                 m_axis_tuser,
  output logic                       m_axis_tlast,
  // configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_AW-1:0]     paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [7:0]  ack_code_q, status_code_q, wifi_code_q, mqtt_code_q, weather_code_q;
  logic [15:0] power_wait_q, ack_wait_q, conn_wait_q;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_code_q     <= 8'd0;
      status_code_q  <= 8'd1;
      wifi_code_q    <= 8'd2;
      mqtt_code_q    <= 8'd3;
      weather_code_q <= 8'd4;
      power_wait_q   <= 16'd500;
      ack_wait_q     <= 16'd100;
      conn_wait_q    <= 16'd5000;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_ACK_CODE:     ack_code_q     <= pwdata[7:0];
        REG_STATUS_CODE:  status_code_q  <= pwdata[7:0];
        REG_WIFI_CODE:    wifi_code_q    <= pwdata[7:0];
        REG_MQTT_CODE:    mqtt_code_q    <= pwdata[7:0];
        REG_WEATHER_CODE: weather_code_q <= pwdata[7:0];
        REG_POWER_WAIT:   power_wait_q   <= pwdata[15:0];
        REG_ACK_WAIT:     ack_wait_q     <= pwdata[15:0];
        REG_CONN_WAIT:    conn_wait_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_ACK_CODE:     prdata = {24'd0, ack_code_q};
      REG_STATUS_CODE:  prdata = {24'd0, status_code_q};
      REG_WIFI_CODE:    prdata = {24'd0, wifi_code_q};
      REG_MQTT_CODE:    prdata = {24'd0, mqtt_code_q};
      REG_WEATHER_CODE: prdata = {24'd0, weather_code_q};
      REG_POWER_WAIT:   prdata = {16'd0, power_wait_q};
      REG_ACK_WAIT:     prdata = {16'd0, ack_wait_q};
      REG_CONN_WAIT:    prdata = {16'd0, conn_wait_q};
      default:          prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input fields
  logic               in_usb, in_sok, in_pok;
  logic [7:0]         in_type, in_arg;
  logic [31:0]        in_pres, in_hum;
  logic signed [31:0] in_temp;
  logic               push;

  assign in_usb  = s_axis_tdata[0];
  assign in_sok  = s_axis_tdata[1];
  assign in_pok  = s_axis_tdata[2];
  assign in_type = s_axis_tdata[10:3];
  assign in_arg  = s_axis_tdata[18:11];
  assign in_pres = s_axis_tdata[50:19];
  assign in_temp = s_axis_tdata[82:51];
  assign in_hum  = s_axis_tdata[114:83];
  assign push    = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // Sequencer state
  logic [3:0]         phase_q, phase_d;
  logic [15:0]        wait_q, wait_d, wait_dec;
  logic [6:0]         poll_q, poll_d, poll_dec;
  logic [8:0]         flags_q, flags_d;
  logic [31:0]        held_p_q, held_p_d, held_h_q, held_h_d;
  logic signed [31:0] held_t_q, held_t_d;
  logic               listen_q, listen_d;

  action_e            m_act;
  logic [7:0]         m_code;
  logic               m_pay;
  logic               poll_emit;
  logic               post_acc;

  assign wait_dec = (wait_q != 16'd0) ? (wait_q - 16'd1) : 16'd0;
  assign poll_dec = (poll_q != 7'd0) ? (poll_q - 7'd1) : 7'd0;

  always_comb begin
    phase_d   = phase_q;
    wait_d    = wait_q;
    poll_d    = poll_q;
    flags_d   = flags_q;
    held_p_d  = held_p_q;
    held_t_d  = held_t_q;
    held_h_d  = held_h_q;
    listen_d  = listen_q;
    m_act     = ACT_NONE;
    m_code    = 8'd0;
    m_pay     = 1'b0;
    poll_emit = 1'b0;
    post_acc  = 1'b0;

    if (push) begin
      case (s_axis_tuser)
        FUNC_TICK: begin
          if (in_usb) begin
            phase_d = PH_IDLE;
          end else begin
            wait_d = wait_dec;
            // phase machine
            unique case (phase_q)
              PH_IDLE: begin
                if (flags_q[FL_POST]) begin
                  listen_d = 1'b1;
                  m_act    = ACT_POWER_ON;
                  wait_d   = power_wait_q;
                  phase_d  = PH_POWER_WAIT;
                end
              end
              PH_POWER_WAIT: begin
                if (wait_dec == 16'd0 && in_sok) begin
                  m_act   = ACT_SEND;
                  m_code  = wifi_code_q;
                  wait_d  = ack_wait_q;
                  phase_d = PH_WIFI_ACK;
                end
              end
              PH_WIFI_ACK: begin
                if (flags_q[FL_WIFI_ACK]) begin
                  phase_d = PH_WIFI_CONN;
                  wait_d  = conn_wait_q;
                end else if (wait_dec == 16'd0) begin
                  phase_d = PH_POWER_WAIT;
                end
              end
              PH_WIFI_CONN: begin
                if (flags_q[FL_WIFI_CONN]) begin
                  if (in_sok) begin
                    m_act   = ACT_SEND;
                    m_code  = mqtt_code_q;
                    wait_d  = ack_wait_q;
                    phase_d = PH_MQTT_ACK;
                  end
                end else if (wait_dec == 16'd0) begin
                  phase_d = PH_SHUTDOWN;
                end
              end
              PH_MQTT_ACK: begin
                if (flags_q[FL_MQTT_ACK]) begin
                  phase_d = PH_MQTT_CONN;
                  wait_d  = conn_wait_q;
                end else if (wait_dec == 16'd0) begin
                  phase_d = PH_WIFI_CONN;
                end
              end
              PH_MQTT_CONN: begin
                if (flags_q[FL_MQTT_CONN]) begin
                  if (in_sok) begin
                    m_act   = ACT_SEND;
                    m_code  = weather_code_q;
                    m_pay   = 1'b1;
                    wait_d  = ack_wait_q;
                    phase_d = PH_POST_ACK;
                  end
                end else if (wait_dec == 16'd0) begin
                  phase_d = PH_SHUTDOWN;
                end
              end
              PH_POST_ACK: begin
                if (flags_q[FL_POST_ACK]) begin
                  phase_d = PH_POST_WAIT;
                  wait_d  = conn_wait_q;
                end else if (wait_dec == 16'd0) begin
                  phase_d = PH_MQTT_CONN;
                end
              end
              PH_POST_WAIT: begin
                if (flags_q[FL_WPOSTED]) begin
                  flags_d[FL_POSTED] = 1'b1;
                  phase_d            = PH_SHUTDOWN;
                end else if (wait_dec == 16'd0) begin
                  phase_d = PH_SHUTDOWN;
                end
              end
              PH_SHUTDOWN: begin
                m_act                = ACT_POWER_OFF;
                flags_d              = 9'd0;
                flags_d[FL_POSTED]   = flags_q[FL_POSTED];
                flags_d[FL_COMPLETE] = 1'b1;
                phase_d              = PH_IDLE;
              end
              default: ;  // unreachable phases hold
            endcase

            // status poll timer, counts down on every tick; reloads and polls only while the machine is busy
            poll_d = poll_dec;
            if (poll_dec == 7'd0 && phase_d != PH_IDLE) begin
              poll_d    = in_pok ? POLL_OK_RELOAD : POLL_RETRY_RELOAD;
              poll_emit = in_pok;
            end
          end
        end

        FUNC_PACKET: begin
          if (listen_q) begin
            if (in_type == ack_code_q) begin
              // first matching command wins
              if (in_arg == wifi_code_q) begin
                flags_d[FL_WIFI_ACK] = 1'b1;
              end else if (in_arg == mqtt_code_q) begin
                flags_d[FL_MQTT_ACK] = 1'b1;
              end else if (in_arg == weather_code_q) begin
                flags_d[FL_POST_ACK] = 1'b1;
              end
            end else if (in_type == status_code_q) begin
              flags_d[FL_WIFI_CONN] = in_arg[ST_WIFI_CONN];
              flags_d[FL_MQTT_CONN] = in_arg[ST_MQTT_CONN];
              flags_d[FL_WPOSTED]   = in_arg[ST_WPOSTED];
            end
          end
        end

        FUNC_POST: begin
          if (!flags_q[FL_POST]) begin
            held_p_d             = in_pres;
            held_t_d             = in_temp;
            held_h_d             = in_hum;
            flags_d[FL_POSTED]   = 1'b0;
            flags_d[FL_COMPLETE] = 1'b0;
            flags_d[FL_POST]     = 1'b1;
            post_acc             = 1'b1;
          end
        end

        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      wait_q   <= 16'd0;
      poll_q   <= 7'd0;
      flags_q  <= 9'd0;
      held_p_q <= 32'd0;
      held_t_q <= 32'sd0;
      held_h_q <= 32'd0;
      listen_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      wait_q   <= wait_d;
      poll_q   <= poll_d;
      flags_q  <= flags_d;
      held_p_q <= held_p_d;
      held_t_q <= held_t_d;
      held_h_q <= held_h_d;
      listen_q <= listen_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Build the queue entry for this item
  lps_entry_t ent_new;
  logic       has_m;

  assign has_m = (m_act != ACT_NONE);

  always_comb begin
    ent_new.action      = has_m ? m_act : (poll_emit ? ACT_SEND : ACT_NONE);
    ent_new.code        = has_m ? m_code : (poll_emit ? status_code_q : 8'd0);
    ent_new.temperature = m_pay ? held_t_q : 32'sd0;
    ent_new.pressure    = m_pay ? held_p_q : 32'd0;
    ent_new.humidity    = m_pay ? held_h_q : 32'd0;
    ent_new.post_acc    = post_acc;
    ent_new.two         = has_m && poll_emit;
    ent_new.poll_code   = status_code_q;
    ent_new.posted      = flags_d[FL_POSTED];
    ent_new.complete    = flags_d[FL_COMPLETE];
  end

  // ---------------------------------------------------------------------------
  // Two-entry item queue; the head entry gives one or two result beats
  lps_entry_t ent_q [2];
  logic       wr_ptr_q, rd_ptr_q, beat_q;
  logic [1:0] cnt_q;
  lps_entry_t head;
  logic       out_last, pop;

  assign s_axis_tready = !cnt_q[1];
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign head          = ent_q[rd_ptr_q];
  assign out_last      = !head.two || beat_q;
  assign pop           = m_axis_tvalid && m_axis_tready && out_last;

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= ent_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      beat_q   <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        beat_q <= !out_last;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // Result beat
  always_comb begin
    if (beat_q) begin
      m_axis_tuser = ACT_SEND;
      m_axis_tdata = {5'd0, head.complete, head.posted, 1'b0,
                      96'd0, head.poll_code};
    end else begin
      m_axis_tuser = head.action;
      m_axis_tdata = {5'd0, head.complete, head.posted, head.post_acc,
                      head.humidity, head.pressure, head.temperature, head.code};
    end
  end

  assign m_axis_tlast = out_last;

endmodule

`default_nettype wire

// ----- rtl/lps_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "link_post_sequencer_macros.svh"

module lps_checker
  import lps_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tready,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic [1:0]            m_axis_tuser,
  input wire logic                  m_axis_tlast
);

  // whole result beat, and shorthand conditions on it
  logic [OUT_DATA_W+2:0] out_beat;
  logic                  out_stall;
  logic                  no_send;
  logic                  acc_beat;
  logic                  none_last;

  assign out_beat  = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign no_send   = m_axis_tvalid && (m_axis_tuser != ACT_SEND);
  assign acc_beat  = m_axis_tvalid && m_axis_tdata[104];
  assign none_last = (m_axis_tuser == ACT_NONE) && m_axis_tlast;

  // a stalled result beat holds
  `LPS_ASSERT_NXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_beat), "result not held")

  // input is only held off while results are queued
  `LPS_ASSERT_IMP(a_ready_backlog, !s_axis_tready, m_axis_tvalid, "input stalled, queue empty")

  // command code only on a send
  `LPS_ASSERT_IMP(a_code_send, no_send, m_axis_tdata[7:0] == 8'd0, "command code without send")

  // payloads only on a send
  `LPS_ASSERT_IMP(a_pay_send, no_send, m_axis_tdata[103:8] == 96'd0, "payload without send")

  // an accepted post is a lone result with no action
  `LPS_ASSERT_IMP(a_post_acc, acc_beat, none_last, "post accept on wrong beat")

endmodule

bind link_post_sequencer lps_checker u_lps_checker (.*);

`default_nettype wire
